[rtl/b32enc_pkg.sv]
// Shared types, constants and helper functions for the base32 stream encoder.
`default_nettype none

package b32enc_pkg;

    // Group geometry.
    localparam int GroupLen      = 5;
    localparam int CharsPerGroup = 8;
    localparam int GroupBits     = 8 * GroupLen;
    localparam int QueueDepth    = 2;

    // Character codes.
    localparam logic [7:0] CharA   = 8'h41;  // 'A'
    localparam logic [7:0] Char2   = 8'h32;  // '2'
    localparam logic [7:0] CharPad = 8'h3D;  // '='
    localparam logic [4:0] LettersCount = 5'd26;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_beat;

    // One output beat.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_group;
    } t_out_beat;

    // One finished group handed from the front end to the back end.
    typedef struct packed {
        logic [GroupBits-1:0] bits;
        logic [2:0]           nbytes;  // 1..5
    } t_group;

    // Map a 5-bit index to its alphabet character.
    function automatic logic [7:0] index_to_char(input logic [4:0] idx);
        logic [7:0] ch;
        if (idx < LettersCount) begin
            ch = CharA + {3'b000, idx};
        end else begin
            ch = Char2 + {3'b000, idx - LettersCount};
        end
        return ch;
    endfunction

    // Number of leading characters that carry data for a group of n bytes.
    function automatic logic [3:0] data_chars(input logic [2:0] n);
        logic [3:0] k;
        unique case (n)
            3'd1:    k = 4'd2;
            3'd2:    k = 4'd4;
            3'd3:    k = 4'd5;
            3'd4:    k = 4'd7;
            default: k = 4'd8;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/b32enc_front.sv]
// Front end: gathers input bytes into groups of up to five and issues each finished group.
`default_nettype none

module b32enc_front
    import b32enc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_beat i_in_beat,
    input  wire logic     i_q_full,
    output logic          o_push,
    output t_group        o_group
);

    logic [7:0] r_bytes [4];
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       accept;
    logic       complete;
    logic [2:0] nbytes;
    logic [GroupBits-1:0] bits;

    // The input waits only when the group queue has no room.
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign nbytes     = r_count + 3'd1;
    assign complete   = (r_count == 3'd4) || i_in_beat.end_of_data;

    // Assemble the zero-filled group, the new byte taking slot r_count.
    always_comb begin
        for (int i = 0; i < GroupLen; i++) begin
            if (3'(i) < r_count) begin
                bits[GroupBits-1-8*i -: 8] = r_bytes[i];
            end else if (3'(i) == r_count) begin
                bits[GroupBits-1-8*i -: 8] = i_in_beat.data_byte;
            end else begin
                bits[GroupBits-1-8*i -: 8] = 8'h00;
            end
        end
    end

    assign o_push         = accept && complete;
    assign o_group.bits   = bits;
    assign o_group.nbytes = nbytes;

    // Byte count of the open group.
    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = complete ? 3'd0 : nbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Byte store; the fifth byte of a group is never stored.
    always_ff @(posedge i_clk) begin
        if (accept && r_count < 3'd4) begin
            r_bytes[r_count[1:0]] <= i_in_beat.data_byte;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("open group holds more than four bytes");
`endif

endmodule

`default_nettype wire

[rtl/b32enc_queue.sv]
// Short queue of finished groups between the front end and the back end.
`default_nettype none

module b32enc_queue
    import b32enc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_group,
    output logic        o_full,
    output logic        o_valid,
    input  wire logic   i_pop,
    output t_group      o_group
);

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    t_group            r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CntW'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_group = r_mem[r_rd];

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(i_push) - CntW'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("group pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("group popped from an empty queue");
`endif

endmodule

`default_nettype wire

[rtl/b32enc_back.sv]
// Back end: a queued group becomes eight characters, one per unstalled cycle.
`default_nettype none

module b32enc_back
    import b32enc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  wire t_group i_q_group,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output t_out_beat   o_out_beat
);

    logic                 r_busy;
    logic [2:0]           r_idx;
    logic [3:0]           r_keep;
    logic [GroupBits-1:0] r_bits;
    logic                 r_out_valid;
    t_out_beat            r_out;
    logic                 advance;
    logic                 last_char;
    logic [7:0]           ch;

    // The output register moves when empty or when its beat is taken.
    assign advance   = !r_out_valid || !i_out_stall;
    assign last_char = r_busy && (r_idx == 3'd7);
    assign o_pop     = i_q_valid && (!r_busy || (advance && last_char));

    // Current character: top five bits of the shifting group, or a pad.
    assign ch = ({1'b0, r_idx} < r_keep) ? index_to_char(r_bits[GroupBits-1 -: 5]) : CharPad;

    // Group shifter and character counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (r_busy && advance) begin
            r_idx <= r_idx + 3'd1;
            if (last_char) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits <= i_q_group.bits;
            r_keep <= data_chars(i_q_group.nbytes);
        end else if (r_busy && advance) begin
            r_bits <= r_bits << 5;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_busy) begin
            r_out.out_char      <= ch;
            r_out.last_of_group <= last_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`ifndef SYNTHESIS
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_of_group) |-> (r_idx == 3'd0))
        else $error("group end shown while the character counter is mid-group");
`endif

endmodule

`default_nettype wire

[rtl/base32_stream_encoder.sv]
// Top level of the base32 stream encoder.
// Usage:
//   Input channel: one raw byte per beat, with end_of_data on the final byte
//   of the data. Output channel: one ASCII character per beat, with
//   last_of_group on the eighth character of every group.
//   Five bytes, or fewer ending in end_of_data, make one group of eight
//   characters; a short group is zero-filled and padded with '='.
// Path: a completed group is written to the group queue, then loaded into
//   the back-end shifter, whose first character goes to the output register.
// Throughput: the front end takes a byte every cycle while its two-entry
//   group queue has room; the back end sends one character per cycle while
//   the output is not stalled. Each group of five bytes yields eight
//   characters, so the back end sets the sustained rate.
// Reset: synchronous, active low; it empties the open group, the queue and
//   the output register.
// Output stall: the current character holds; the back end and then the
//   queue fill, and o_in_stall rises once the queue holds two groups.
`default_nettype none

module base32_stream_encoder
    import b32enc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    logic   q_full;
    logic   q_push;
    logic   q_valid;
    logic   q_pop;
    t_group front_group;
    t_group q_group;

    b32enc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_group    (front_group)
    );

    b32enc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (front_group),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_group (q_group)
    );

    b32enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_group   (q_group),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the base32 stream encoder.
`timescale 1ns / 100ps

module tb_top;
    import b32enc_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int DrainCycles  = 20;
    localparam int HoldCycles   = 100;
    localparam int RandomBytes  = 260;
    localparam int PressureLen  = 40;
    localparam int MaxReported  = 10;

    localparam logic [7:0] SymLetterA = 8'h41;  // 'A'
    localparam logic [7:0] SymDigit2  = 8'h32;  // '2'
    localparam logic [7:0] SymPad     = 8'h3D;  // '='

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;

    // Predictor state: bytes of the open group and how many are held.
    logic [7:0] grp_bytes [4];
    int         grp_count;

    // Characters predicted but not yet seen on the output.
    t_out_beat  pending_chars [$];

    // Stream under construction for the sender.
    logic [7:0] stream_buf [$];

    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int stall_left;
    int cycle_count;
    int error_count;
    int bytes_sent;
    int chars_checked;
    int groups_predicted;
    int padded_groups;

    base32_stream_encoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 20);
    endfunction

    // Base32 alphabet: 'A'..'Z' then '2'..'7'.
    function automatic logic [7:0] b32_symbol(input logic [4:0] idx);
        if (idx < 5'd26) begin
            return SymLetterA + 8'(idx);
        end
        return SymDigit2 + 8'(idx - 5'd26);
    endfunction

    // Account for one accepted byte; a closed group yields eight characters.
    task automatic predict_group(input logic [7:0] b, input logic eod);
        logic [39:0] bits;
        logic [7:0]  cur;
        logic [4:0]  idx;
        t_out_beat   ch;
        int          n;
        int          keep;
        n = grp_count + 1;
        if (n < 5 && !eod) begin
            grp_bytes[grp_count] = b;
            grp_count = n;
            return;
        end
        bits = '0;
        for (int i = 0; i < 5; i++) begin
            if (i >= n) begin
                cur = 8'h00;
            end else if (i == n - 1) begin
                cur = b;
            end else begin
                cur = grp_bytes[i];
            end
            bits = {bits[31:0], cur};
        end
        case (n)
            1: keep = 2;
            2: keep = 4;
            3: keep = 5;
            4: keep = 7;
            default: keep = 8;
        endcase
        for (int i = 0; i < 8; i++) begin
            idx = bits[39 - 5 * i -: 5];
            ch.out_char      = (i < keep) ? b32_symbol(idx) : SymPad;
            ch.last_of_group = (i == 7);
            pending_chars.push_back(ch);
        end
        groups_predicted++;
        if (keep < 8) begin
            padded_groups++;
        end
        grp_count = 0;
    endtask

    // Drive one input beat, wait until it is taken, then maybe idle.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= '{data_byte: b, end_of_data: eod};
        do begin
            @(posedge clk);
        end while (in_stall);
        predict_group(b, eod);
        bytes_sent++;
        gap = pick_gap(tx_idle_on);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Send the buffered stream, flagging the final byte if asked.
    task automatic send_stream(input bit close);
        for (int i = 0; i < stream_buf.size(); i++) begin
            send_byte(stream_buf[i], close && (i == stream_buf.size() - 1));
        end
        stream_buf.delete();
    endtask

    // Extremes, every short-group size, a full group and an end mark on the fifth byte.
    task automatic test_directed();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        stream_buf = '{8'h00};
        send_stream(1'b1);
        stream_buf = '{8'hFF};
        send_stream(1'b1);
        stream_buf = '{8'hFF, 8'h00};
        send_stream(1'b1);
        stream_buf = '{8'h00, 8'hFF, 8'hA5};
        send_stream(1'b1);
        stream_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_stream(1'b1);
        // Full group without an end mark.
        stream_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_stream(1'b0);
        // "fooba" closed on its fifth byte.
        stream_buf = '{8'h66, 8'h6F, 8'h6F, 8'h62, 8'h61};
        send_stream(1'b1);
    endtask

    // Random streams of random length with idling on both sides.
    task automatic test_random_streams();
        int len;
        int sent;
        int mode;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        sent = 0;
        while (sent < RandomBytes) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                               : $urandom_range(1, 12);
            mode = $urandom_range(0, 9);
            for (int i = 0; i < len; i++) begin
                // Some streams lean on the all-zero and all-one bytes.
                if (mode == 0) begin
                    stream_buf.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
                end else begin
                    stream_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            sent += len;
            // Quiet stretches with no idling at all.
            if (mode == 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            send_stream(1'b1);
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
        end
    endtask

    // Long output hold-off while the sender keeps offering bytes.
    task automatic test_output_holdoff();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 1'b1;
        for (int i = 0; i < PressureLen; i++) begin
            stream_buf.push_back(8'($urandom_range(0, 255)));
        end
        send_stream(1'b1);
        rx_idle_on = 1'b1;
    endtask

    // Output stall driver: random stretches, plus one long hold-off on request.
    initial begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HoldCycles;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 30) begin
                stall_left = pick_gap(1'b1);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MaxReported) begin
            $display("tb_top: error at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Compare each output beat against the oldest predicted character.
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_chars.size() == 0) begin
                note_error($sformatf("unexpected char 0x%02h last=%0b",
                                     out_beat.out_char, out_beat.last_of_group));
            end else begin
                want = pending_chars.pop_front();
                if (out_beat.out_char !== want.out_char
                        || out_beat.last_of_group !== want.last_of_group) begin
                    note_error($sformatf("char %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                                         chars_checked, want.out_char, want.last_of_group,
                                         out_beat.out_char, out_beat.last_of_group));
                end
            end
            chars_checked++;
        end
    end

    // Watchdog on the whole run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: timeout after %0d cycles", cycle_count);
        $display("tb_top: FAIL");
        $finish;
    end

    // Main sequence.
    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_beat    = '0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 1'b0;
        grp_count  = 0;
        for (int i = 0; i < 4; i++) begin
            grp_bytes[i] = 8'h00;
        end
        error_count      = 0;
        bytes_sent       = 0;
        chars_checked    = 0;
        groups_predicted = 0;
        padded_groups    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_streams();
        test_output_holdoff();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        $display("tb_top: %0d bytes encoded into %0d groups (%0d padded), %0d characters checked",
                 bytes_sent, groups_predicted, padded_groups, chars_checked);
        $display("tb_top: covered short and full groups, random idling and a %0d-cycle hold-off",
                 HoldCycles);
        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: %0d errors", error_count);
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
